// ----- design/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg: shared types, constants and match function for the subnet whitelist
// Holds the queued word format and the prefix compare used by the scan engine.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int NET_W             = 32;
    localparam int PLEN_W            = 6;
    localparam int SLOT_W            = 4;
    localparam int ENTRY_W           = NET_W + PLEN_W;

    localparam logic [PLEN_W-1:0] MAX_PREFIX = PLEN_W'(32);
    localparam logic [NET_W-1:0]  ALL_ONES   = 32'hFFFF_FFFF;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic              lookup;
        logic [SLOT_W-1:0] slot;
        logic [NET_W-1:0]  net;
        logic [PLEN_W-1:0] plen;
        logic [NET_W-1:0]  dest;
    } item_t;

    function automatic logic entry_match(
        input logic [NET_W-1:0]  dest,
        input logic [NET_W-1:0]  net,
        input logic [PLEN_W-1:0] plen
    );
        logic [NET_W-1:0] mask;
        logic             hit;
        begin
            if (plen == '0)
                mask = '0;
            else
                mask = ALL_ONES << (MAX_PREFIX - plen);
            if (plen > MAX_PREFIX)
                hit = 1'b0;
            else
                hit = (((net ^ dest) & mask) == '0);
            return hit;
        end
    endfunction

endpackage

// ----- design/swm_ram.sv -----
// ----------------------------------------------------------------------------
// swm_ram: generic single write port ram with registered read
// One write and one read per cycle; contents are undefined until written.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = swm_pkg::ENTRY_W,
    parameter int DEPTH = swm_pkg::TABLE_ENTRIES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/swm_front.sv -----
// ----------------------------------------------------------------------------
// swm_front: request intake, classification and two-word queue
// Drops busy-time starts and writes past the table; queues the rest in order.
// ----------------------------------------------------------------------------
module swm_front #(
    parameter int TABLE_ENTRIES = swm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [swm_pkg::SLOT_W-1:0]  entry_index,
    input  logic [swm_pkg::NET_W-1:0]   subnet_addr,
    input  logic [swm_pkg::PLEN_W-1:0]  subnet_len,
    input  logic [swm_pkg::NET_W-1:0]   dest_ip,
    output logic                        q_valid,
    output swm_pkg::item_t              q_item,
    input  logic                        q_pop
);

    swm_pkg::item_t fifo_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           accept;
    logic           slot_ok;
    logic           push;
    swm_pkg::item_t in_item;

    assign busy    = (count_reg == 2'd2);
    assign accept  = start && !busy;
    assign slot_ok = ({{(32 - swm_pkg::SLOT_W){1'b0}}, entry_index} < 32'(TABLE_ENTRIES));
    assign push    = accept && ((req_type == swm_pkg::REQ_LOOKUP) || slot_ok);

    always_comb
    begin
        in_item.lookup = (req_type == swm_pkg::REQ_LOOKUP);
        in_item.slot   = entry_index;
        in_item.net    = subnet_addr;
        in_item.plen   = subnet_len;
        in_item.dest   = dest_ip;
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (count_reg != 2'd0))
        else $error("queue popped while empty");
`endif

endmodule

// ----- design/swm_back.sv -----
// ----------------------------------------------------------------------------
// swm_back: table owner and lookup scan engine
// Applies queued writes and scans the table one entry per cycle for lookups.
// ----------------------------------------------------------------------------
module swm_back #(
    parameter int TABLE_ENTRIES = swm_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  swm_pkg::item_t q_item,
    output logic           q_pop,
    output logic           done,
    output logic           allowed
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              chk_idx_reg, chk_idx_next;
    logic [swm_pkg::NET_W-1:0]     dest_reg, dest_next;
    logic [TABLE_ENTRIES-1:0]      valid_reg, valid_next;
    logic                          done_reg, done_next;
    logic                          allowed_reg, allowed_next;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [IDX_W-1:0]              ram_raddr;
    logic [swm_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [IDX_W+swm_pkg::SLOT_W-1:0] slot_ext;
    logic [swm_pkg::NET_W-1:0]     ent_net;
    logic [swm_pkg::PLEN_W-1:0]    ent_plen;
    logic                          ent_hit;
    logic                          is_last;

    assign slot_ext  = {{IDX_W{1'b0}}, q_item.slot};
    assign ram_waddr = slot_ext[IDX_W-1:0];
    assign q_pop     = q_valid && (state_reg == S_IDLE);
    assign ram_we    = q_pop && !q_item.lookup;

    assign ent_net  = valid_reg[chk_idx_reg]
                      ? ram_rdata[swm_pkg::ENTRY_W-1:swm_pkg::PLEN_W] : '0;
    assign ent_plen = ram_rdata[swm_pkg::PLEN_W-1:0];
    assign ent_hit  = swm_pkg::entry_match(dest_reg, ent_net, ent_plen);
    assign is_last  = (chk_idx_reg == LAST_IDX);

    always_comb
    begin
        state_next   = state_reg;
        chk_idx_next = chk_idx_reg;
        dest_next    = dest_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        allowed_next = allowed_reg;
        ram_raddr    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ram_we)
                    valid_next[ram_waddr] = 1'b1;
                if (q_pop && q_item.lookup)
                begin
                    dest_next    = q_item.dest;
                    chk_idx_next = '0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ram_raddr = is_last ? chk_idx_reg : chk_idx_reg + 1'b1;
                if (ent_net == '0)
                begin
                    done_next    = 1'b1;
                    allowed_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else if (ent_hit)
                begin
                    done_next    = 1'b1;
                    allowed_next = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (is_last)
                begin
                    done_next    = 1'b1;
                    allowed_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    chk_idx_next = chk_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    swm_ram #(
        .WIDTH (swm_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({q_item.net, q_item.plen}),
        .re    (1'b1),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        dest_reg    <= dest_next;
        chk_idx_reg <= chk_idx_next;
        allowed_reg <= allowed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    assign done    = done_reg;
    assign allowed = allowed_reg;

`ifndef SYNTHESIS
    a_done_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_SCAN))
        else $error("result strobe without a scan");
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !ram_we)
        else $error("table written during scan");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("back to back result strobes");
`endif

endmodule

// ----- design/subnet_whitelist_match.sv -----
// ----------------------------------------------------------------------------
// subnet_whitelist_match: ipv4 subnet whitelist lookup
// Write words fill table slots; lookup words report whether dest_ip is listed.
// ----------------------------------------------------------------------------
// a write word is queued, then written to the table when the back end is idle
// lookup: queued, then scanned from slot 0 up to a hit, empty slot or last slot
// writes go one per cycle when no scan runs; a scan holds off later queued words
// a two-word queue takes new words while a scan runs; busy when it is full
// reset: rst_n clears queue, control and slot valid bits, so the list is empty
// done is a one-cycle strobe and the receiver cannot stall it
module subnet_whitelist_match #(
    parameter int TABLE_ENTRIES = swm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [swm_pkg::SLOT_W-1:0]  entry_index,
    input  logic [swm_pkg::NET_W-1:0]   subnet_addr,
    input  logic [swm_pkg::PLEN_W-1:0]  subnet_len,
    input  logic [swm_pkg::NET_W-1:0]   dest_ip,
    output logic                        done,
    output logic                        allowed
);

    logic           q_valid;
    logic           q_pop;
    swm_pkg::item_t q_item;

    swm_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .entry_index   (entry_index),
        .subnet_addr   (subnet_addr),
        .subnet_len    (subnet_len),
        .dest_ip       (dest_ip),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    swm_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .done    (done),
        .allowed (allowed)
    );

endmodule
